@@ src/ppust_pkg.sv @@
`timescale 1ns / 1ps

package ppust_pkg;

    localparam int DOT_W      = 9;
    localparam int LINE_W     = 9;
    localparam int PWR_W      = 15;
    localparam int ADDR_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int NT_ADDR_W  = 11;

    localparam int DEF_DOTS_PER_LINE   = 341;
    localparam int DEF_LINES_PER_FRAME = 262;
    localparam int DEF_VBLANK_LINE     = 241;
    localparam int DEF_POWERUP_DOTS    = 30000;

    localparam logic [ADDR_W-1:0] ADDR_STEP_ROW  = 16'd32;
    localparam logic [ADDR_W-1:0] ADDR_STEP_ONE  = 16'd1;
    localparam logic [ADDR_W-1:0] PATTERN_LIMIT  = 16'h2000;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        REG_CONTROL  = 3'd0,
        REG_MASK     = 3'd1,
        REG_STATUS   = 3'd2,
        REG_OAM_ADDR = 3'd3,
        REG_OAM_DATA = 3'd4,
        REG_SCROLL   = 3'd5,
        REG_ADDRESS  = 3'd6,
        REG_DATA     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        t_cmd               command;
        t_reg_idx           register_index;
        logic [BYTE_W-1:0]  wr_value;
        logic [BYTE_W-1:0]  tick_dots;
        logic [BYTE_W-1:0]  fetched_byte;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0]    rd_value;
        logic                 nmi_pulse;
        logic                 frame_done;
        logic                 mem_write_enable;
        logic [NT_ADDR_W-1:0] mem_write_address;
        logic [BYTE_W-1:0]    mem_write_data;
        logic [ADDR_W-1:0]    current_address;
    } t_result;

endpackage

@@ src/ppust_in_stage.sv @@
`timescale 1ns / 1ps

module ppust_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ppust_pkg::t_item i_item,
    output logic             o_valid,
    input  logic             i_take,
    output ppust_pkg::t_item o_item
);
    import ppust_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

@@ src/ppust_core.sv @@
`timescale 1ns / 1ps

module ppust_core #(
    parameter int DOTS_PER_LINE   = ppust_pkg::DEF_DOTS_PER_LINE,
    parameter int LINES_PER_FRAME = ppust_pkg::DEF_LINES_PER_FRAME,
    parameter int VBLANK_LINE     = ppust_pkg::DEF_VBLANK_LINE,
    parameter int POWERUP_DOTS    = ppust_pkg::DEF_POWERUP_DOTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  ppust_pkg::t_item   i_item,
    input  logic               i_mirroring_mode,
    output ppust_pkg::t_result o_result
);
    import ppust_pkg::*;

    localparam logic [DOT_W:0]    DPL_X  = (DOT_W+1)'(DOTS_PER_LINE);
    localparam logic [LINE_W-1:0] LPF_L  = LINE_W'(LINES_PER_FRAME);
    localparam logic [LINE_W-1:0] VBL_L  = LINE_W'(VBLANK_LINE);
    localparam logic [PWR_W-1:0]  PWR_L  = PWR_W'(POWERUP_DOTS);
    localparam logic [PWR_W:0]    PWR_X  = (PWR_W+1)'(POWERUP_DOTS);

    logic [DOT_W-1:0]  r_dot_count,   n_dot_count;
    logic [LINE_W-1:0] r_line_count,  n_line_count;
    logic              r_vblank,      n_vblank;
    logic              r_high_next,   n_high_next;
    logic [ADDR_W-1:0] r_address,     n_address;
    logic [BYTE_W-1:0] r_read_buf,    n_read_buf;
    logic [BYTE_W-1:0] r_control,     n_control;
    logic [BYTE_W-1:0] r_spr_addr,    n_spr_addr;
    logic [BYTE_W-1:0] r_spr_data,    n_spr_data;
    logic [PWR_W-1:0]  r_pwr_dots,    n_pwr_dots;

    logic [DOT_W:0]     dot_sum;
    logic [DOT_W:0]     dot_left;
    logic               dot_over;
    logic [LINE_W-1:0]  line_inc;
    logic [PWR_W:0]     pwr_sum;
    logic               powered;
    logic [ADDR_W-1:0]  addr_stepped;
    logic [11:0]        nt_off;
    logic [NT_ADDR_W-1:0] nt_addr;
    t_result            res;

    assign dot_sum      = {1'b0, r_dot_count} + (DOT_W+1)'(i_item.tick_dots);
    assign dot_over     = dot_sum >= DPL_X;
    assign dot_left     = dot_sum - DPL_X;
    assign line_inc     = r_line_count + LINE_W'(1);
    assign pwr_sum      = {1'b0, r_pwr_dots} + (PWR_W+1)'(i_item.tick_dots);
    assign powered      = r_pwr_dots >= PWR_L;
    assign addr_stepped = r_address + (r_control[2] ? ADDR_STEP_ROW : ADDR_STEP_ONE);
    assign nt_off       = r_address[11:0];
    assign nt_addr      = i_mirroring_mode ? nt_off[10:0] : {nt_off[11], nt_off[9:0]};

    always_comb begin
        n_dot_count  = r_dot_count;
        n_line_count = r_line_count;
        n_vblank     = r_vblank;
        n_high_next  = r_high_next;
        n_address    = r_address;
        n_read_buf   = r_read_buf;
        n_control    = r_control;
        n_spr_addr   = r_spr_addr;
        n_spr_data   = r_spr_data;
        n_pwr_dots   = r_pwr_dots;
        res          = '0;

        case (i_item.command)
            CMD_TICK: begin
                if (!powered) begin
                    n_pwr_dots = (pwr_sum > PWR_X) ? PWR_L : pwr_sum[PWR_W-1:0];
                end
                if (dot_over) begin
                    n_dot_count  = dot_left[DOT_W-1:0];
                    n_line_count = line_inc;
                    if (line_inc == VBL_L) begin
                        n_vblank      = 1'b1;
                        res.nmi_pulse = r_control[7];
                    end
                    if (line_inc >= LPF_L) begin
                        n_line_count   = '0;
                        n_vblank       = 1'b0;
                        res.frame_done = 1'b1;
                    end
                end else begin
                    n_dot_count = dot_sum[DOT_W-1:0];
                end
            end
            CMD_WRITE: begin
                case (i_item.register_index)
                    REG_CONTROL: begin
                        if (powered) begin
                            n_control     = i_item.wr_value;
                            res.nmi_pulse = !r_control[7] && i_item.wr_value[7] && r_vblank;
                        end
                    end
                    REG_OAM_ADDR: n_spr_addr = i_item.wr_value;
                    REG_OAM_DATA: n_spr_data = i_item.wr_value;
                    REG_ADDRESS: begin
                        if (r_high_next) begin
                            n_address   = {i_item.wr_value, 8'h00};
                            n_high_next = 1'b0;
                        end else begin
                            n_address   = {r_address[15:8], i_item.wr_value};
                            n_high_next = 1'b1;
                        end
                    end
                    REG_DATA: begin
                        res.mem_write_enable  = 1'b1;
                        res.mem_write_address = nt_addr;
                        res.mem_write_data    = i_item.wr_value;
                        n_address             = addr_stepped;
                    end
                    default: ;
                endcase
            end
            CMD_READ: begin
                case (i_item.register_index)
                    REG_STATUS: begin
                        res.rd_value = {r_vblank, 7'd0};
                        n_vblank     = 1'b0;
                        n_high_next  = 1'b1;
                    end
                    REG_OAM_DATA: res.rd_value = r_spr_data;
                    REG_DATA: begin
                        if (r_address < PATTERN_LIMIT) begin
                            res.rd_value = r_read_buf;
                            n_read_buf   = i_item.fetched_byte;
                        end
                        n_address = addr_stepped;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        res.current_address = n_address;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_count  <= '0;
            r_line_count <= '0;
            r_vblank     <= 1'b0;
            r_high_next  <= 1'b1;
            r_address    <= '0;
            r_read_buf   <= '0;
            r_control    <= '0;
            r_spr_addr   <= '0;
            r_spr_data   <= '0;
            r_pwr_dots   <= '0;
        end else if (i_advance) begin
            r_dot_count  <= n_dot_count;
            r_line_count <= n_line_count;
            r_vblank     <= n_vblank;
            r_high_next  <= n_high_next;
            r_address    <= n_address;
            r_read_buf   <= n_read_buf;
            r_control    <= n_control;
            r_spr_addr   <= n_spr_addr;
            r_spr_data   <= n_spr_data;
            r_pwr_dots   <= n_pwr_dots;
        end
    end

`ifndef SYNTHESIS
    a_dot_below_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (DOT_W+1)'(r_dot_count) < DPL_X)
        else $error("dot counter reached a full line");

    a_line_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_count < LPF_L)
        else $error("line counter beyond frame");

    a_frame_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && res.frame_done |=> r_line_count == '0 && !r_vblank)
        else $error("frame end without line wrap");

    a_status_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_item.command == CMD_READ && i_item.register_index == REG_STATUS
        |=> !r_vblank && r_high_next)
        else $error("status read did not clear vblank and toggle");

    a_powerup_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pwr_dots <= PWR_L)
        else $error("power-up counter passed its limit");
`endif

endmodule

@@ src/ppust_out_stage.sv @@
`timescale 1ns / 1ps

module ppust_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_load,
    input  ppust_pkg::t_result i_result,
    output logic               o_valid,
    input  logic               i_ready,
    output ppust_pkg::t_result o_result
);
    import ppust_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_load   = i_valid && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ src/ppu_register_port_and_scanline_timer_top.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake                    Payload
// in       sink       i_in_valid / o_in_ready      command, register index, bytes, dots
// out      source     o_out_valid / i_out_ready    read byte, flags, nametable write, address
// cfg      sink       i_cfg_valid / o_cfg_ready    mirroring mode (always ready)
//
// One item per cycle is sustained while the output takes beats. Each taken item enters the
// input register; the combinational state update feeds its result into the result register.
// A stalled output holds its beat while one more item waits in the input register.
// Reset is synchronous and active low; it clears timing, toggle, address and control state.

module ppu_register_port_and_scanline_timer_top #(
    parameter int DOTS_PER_LINE   = ppust_pkg::DEF_DOTS_PER_LINE,
    parameter int LINES_PER_FRAME = ppust_pkg::DEF_LINES_PER_FRAME,
    parameter int VBLANK_LINE     = ppust_pkg::DEF_VBLANK_LINE,
    parameter int POWERUP_DOTS    = ppust_pkg::DEF_POWERUP_DOTS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [1:0]   i_command,
    input  logic [2:0]   i_register_index,
    input  logic [7:0]   i_wr_value,
    input  logic [7:0]   i_tick_dots,
    input  logic [7:0]   i_fetched_byte,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [7:0]   o_rd_value,
    output logic         o_nmi_pulse,
    output logic         o_frame_done,
    output logic         o_mem_write_enable,
    output logic [10:0]  o_mem_write_address,
    output logic [7:0]   o_mem_write_data,
    output logic [15:0]  o_current_address,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_mirroring_mode
);
    import ppust_pkg::*;

    logic    r_mirroring_mode;
    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    advance;
    t_result core_result;
    t_result out_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirroring_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_mirroring_mode <= i_cfg_mirroring_mode;
        end
    end

    assign in_item.command        = t_cmd'(i_command);
    assign in_item.register_index = t_reg_idx'(i_register_index);
    assign in_item.wr_value       = i_wr_value;
    assign in_item.tick_dots      = i_tick_dots;
    assign in_item.fetched_byte   = i_fetched_byte;

    ppust_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .i_take  (advance),
        .o_item  (stage_item)
    );

    ppust_core #(
        .DOTS_PER_LINE   (DOTS_PER_LINE),
        .LINES_PER_FRAME (LINES_PER_FRAME),
        .VBLANK_LINE     (VBLANK_LINE),
        .POWERUP_DOTS    (POWERUP_DOTS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_item           (stage_item),
        .i_mirroring_mode (r_mirroring_mode),
        .o_result         (core_result)
    );

    ppust_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stage_valid),
        .o_load   (advance),
        .i_result (core_result),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_rd_value          = out_result.rd_value;
    assign o_nmi_pulse         = out_result.nmi_pulse;
    assign o_frame_done        = out_result.frame_done;
    assign o_mem_write_enable  = out_result.mem_write_enable;
    assign o_mem_write_address = out_result.mem_write_address;
    assign o_mem_write_data    = out_result.mem_write_data;
    assign o_current_address   = out_result.current_address;

endmodule

@@ tb/ppu_register_port_checker.sv @@
`timescale 1ns / 1ps

module ppu_register_port_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_command,
    input  logic [2:0]  i_register_index,
    input  logic [7:0]  i_wr_value,
    input  logic [7:0]  i_tick_dots,
    input  logic [7:0]  i_fetched_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_rd_value,
    input  logic        i_nmi_pulse,
    input  logic        i_frame_done,
    input  logic        i_mem_write_enable,
    input  logic [10:0] i_mem_write_address,
    input  logic [7:0]  i_mem_write_data,
    input  logic [15:0] i_current_address,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_mirroring_mode,
    output int          o_error_count,
    output int          o_awaited,
    output int          o_frames,
    output int          o_nmis,
    output int          o_nt_writes
);

    import ppust_pkg::*;

    logic                 mirror_vertical;
    logic [DOT_W-1:0]     dot_count;
    logic [LINE_W-1:0]    line_count;
    logic                 vblank;
    logic                 high_byte_next;
    logic [ADDR_W-1:0]    video_addr;
    logic [BYTE_W-1:0]    read_buffer;
    logic [BYTE_W-1:0]    control;
    logic [BYTE_W-1:0]    spr_addr;
    logic [BYTE_W-1:0]    spr_data;
    logic [PWR_W-1:0]     powered_dots;

    t_result awaited_results[$];
    int      error_count;
    int      beat_count;
    int      frames;
    int      nmis;
    int      nt_writes;

    task automatic flag_error(input string what);
        error_count++;
        $display("[%0t] ppu check: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want) begin
            flag_error($sformatf("beat %0d %s is 0x%0h, predicted 0x%0h",
                                 beat_count, name, got, want));
        end
    endtask

    function automatic logic [NT_ADDR_W-1:0] nametable_slot(input logic [ADDR_W-1:0] addr,
                                                            input logic vertical);
        if (vertical) begin
            return addr[10:0];
        end
        return {addr[11], addr[9:0]};
    endfunction

    task automatic step_address();
        video_addr = video_addr + (control[2] ? ADDR_STEP_ROW : ADDR_STEP_ONE);
    endtask

    task automatic predict_beat(input t_item item, output t_result res);
        int           dot_sum;
        int           pwr_sum;
        logic [BYTE_W-1:0] old_control;
        res = '0;
        case (item.command)
            CMD_TICK: begin
                if (powered_dots < DEF_POWERUP_DOTS) begin
                    pwr_sum = powered_dots + item.tick_dots;
                    powered_dots = PWR_W'((pwr_sum > DEF_POWERUP_DOTS) ? DEF_POWERUP_DOTS
                                                                       : pwr_sum);
                end
                dot_sum = dot_count + item.tick_dots;
                if (dot_sum >= DEF_DOTS_PER_LINE) begin
                    dot_sum = dot_sum - DEF_DOTS_PER_LINE;
                    line_count = line_count + 1'b1;
                    if (line_count == DEF_VBLANK_LINE) begin
                        vblank = 1'b1;
                        if (control[7]) begin
                            res.nmi_pulse = 1'b1;
                        end
                    end
                    if (line_count >= DEF_LINES_PER_FRAME) begin
                        line_count = '0;
                        vblank = 1'b0;
                        res.frame_done = 1'b1;
                    end
                end
                dot_count = dot_sum[DOT_W-1:0];
            end
            CMD_WRITE: begin
                case (item.register_index)
                    REG_CONTROL: begin
                        if (powered_dots >= DEF_POWERUP_DOTS) begin
                            old_control = control;
                            control = item.wr_value;
                            if (!old_control[7] && item.wr_value[7] && vblank) begin
                                res.nmi_pulse = 1'b1;
                            end
                        end
                    end
                    REG_OAM_ADDR: spr_addr = item.wr_value;
                    REG_OAM_DATA: spr_data = item.wr_value;
                    REG_ADDRESS: begin
                        if (high_byte_next) begin
                            video_addr = {item.wr_value, 8'h00};
                        end else begin
                            video_addr = {video_addr[15:8], item.wr_value};
                        end
                        high_byte_next = !high_byte_next;
                    end
                    REG_DATA: begin
                        res.mem_write_enable = 1'b1;
                        res.mem_write_address = nametable_slot(video_addr, mirror_vertical);
                        res.mem_write_data = item.wr_value;
                        step_address();
                    end
                    default: ;
                endcase
            end
            CMD_READ: begin
                case (item.register_index)
                    REG_STATUS: begin
                        res.rd_value = {vblank, 7'b0};
                        vblank = 1'b0;
                        high_byte_next = 1'b1;
                    end
                    REG_OAM_DATA: res.rd_value = spr_data;
                    REG_DATA: begin
                        if (video_addr < PATTERN_LIMIT) begin
                            res.rd_value = read_buffer;
                            read_buffer = item.fetched_byte;
                        end
                        step_address();
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        res.current_address = video_addr;
    endtask

    always @(posedge i_clk) begin : watch
        t_item   item;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            mirror_vertical = 1'b0;
            dot_count = '0;
            line_count = '0;
            vblank = 1'b0;
            high_byte_next = 1'b1;
            video_addr = '0;
            read_buffer = '0;
            control = '0;
            spr_addr = '0;
            spr_data = '0;
            powered_dots = '0;
            awaited_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                mirror_vertical = i_cfg_mirroring_mode;
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_rd_value, i_nmi_pulse, i_frame_done, i_mem_write_enable,
                       i_mem_write_address, i_mem_write_data, i_current_address};
                if (awaited_results.size() == 0) begin
                    flag_error($sformatf("beat %0d arrived with nothing predicted", beat_count));
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("rd_value", 16'(got.rd_value), 16'(want.rd_value));
                    compare_field("nmi_pulse", 16'(got.nmi_pulse), 16'(want.nmi_pulse));
                    compare_field("frame_done", 16'(got.frame_done), 16'(want.frame_done));
                    compare_field("mem_write_enable", 16'(got.mem_write_enable),
                                  16'(want.mem_write_enable));
                    compare_field("mem_write_address", 16'(got.mem_write_address),
                                  16'(want.mem_write_address));
                    compare_field("mem_write_data", 16'(got.mem_write_data),
                                  16'(want.mem_write_data));
                    compare_field("current_address", got.current_address,
                                  want.current_address);
                end
                beat_count++;
            end
            if (i_in_valid && i_in_ready) begin
                item = {i_command, i_register_index, i_wr_value, i_tick_dots, i_fetched_byte};
                predict_beat(item, want);
                frames += want.frame_done;
                nmis += want.nmi_pulse;
                nt_writes += want.mem_write_enable;
                awaited_results.push_back(want);
            end
        end
        o_awaited <= awaited_results.size();
        o_error_count <= error_count;
        o_frames <= frames;
        o_nmis <= nmis;
        o_nt_writes <= nt_writes;
    end

endmodule

@@ tb/tb_ppu_register_port_and_scanline_timer_top.sv @@
`timescale 1ns / 1ps

module tb_ppu_register_port_and_scanline_timer_top;

    import ppust_pkg::*;

    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam int         STALL_LIMIT = 5000;
    localparam int         PHASE_ITEMS = 280;
    localparam int         HOLD_CYCLES = 80;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [1:0]  command      = '0;
    logic [2:0]  reg_index    = '0;
    logic [7:0]  wr_value     = '0;
    logic [7:0]  tick_dots    = '0;
    logic [7:0]  fetched_byte = '0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [7:0]  rd_value;
    logic        nmi_pulse;
    logic        frame_done;
    logic        mem_we;
    logic [10:0] mem_waddr;
    logic [7:0]  mem_wdata;
    logic [15:0] cur_addr;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic        cfg_mode     = 1'b0;

    int error_count;
    int awaited;
    int frames;
    int nmis;
    int nt_writes;
    int items_sent;
    int beats_taken;

    ppu_register_port_and_scanline_timer_top uut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_command            (command),
        .i_register_index     (reg_index),
        .i_wr_value           (wr_value),
        .i_tick_dots          (tick_dots),
        .i_fetched_byte       (fetched_byte),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_rd_value           (rd_value),
        .o_nmi_pulse          (nmi_pulse),
        .o_frame_done         (frame_done),
        .o_mem_write_enable   (mem_we),
        .o_mem_write_address  (mem_waddr),
        .o_mem_write_data     (mem_wdata),
        .o_current_address    (cur_addr),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_cfg_mirroring_mode (cfg_mode)
    );

    ppu_register_port_checker u_check (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .i_in_ready           (in_ready),
        .i_command            (command),
        .i_register_index     (reg_index),
        .i_wr_value           (wr_value),
        .i_tick_dots          (tick_dots),
        .i_fetched_byte       (fetched_byte),
        .i_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .i_rd_value           (rd_value),
        .i_nmi_pulse          (nmi_pulse),
        .i_frame_done         (frame_done),
        .i_mem_write_enable   (mem_we),
        .i_mem_write_address  (mem_waddr),
        .i_mem_write_data     (mem_wdata),
        .i_current_address    (cur_addr),
        .i_cfg_valid          (cfg_valid),
        .i_cfg_ready          (cfg_ready),
        .i_cfg_mirroring_mode (cfg_mode),
        .o_error_count        (error_count),
        .o_awaited            (awaited),
        .o_frames             (frames),
        .o_nmis               (nmis),
        .o_nt_writes          (nt_writes)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] addr_byte();
        if ($urandom_range(0, 1) == 1) begin
            return 8'($urandom_range(0, 8'h3F));
        end
        return rand_byte();
    endfunction

    task automatic send_beat(input logic [1:0] cmd, input logic [2:0] idx,
                             input logic [7:0] wb, input logic [7:0] dots,
                             input logic [7:0] fb);
        int gap;
        gap = ((items_sent % 100) < 30) ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        reg_index <= idx;
        wr_value <= wb;
        tick_dots <= dots;
        fetched_byte <= fb;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (awaited != 0);
    endtask

    task automatic set_mirroring(input logic vertical);
        drain();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_mode <= vertical;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_tick();
        logic [7:0] dots;
        if ($urandom_range(0, 9) == 0) begin
            dots = rand_byte();
        end else begin
            dots = 8'($urandom_range(224, 255));
        end
        send_beat(CMD_TICK, REG_CONTROL, rand_byte(), dots, rand_byte());
    endtask

    task automatic run_random(input int target);
        int         done_items;
        int         pick;
        int         burst;
        logic [2:0] idx;
        logic [1:0] cmd;
        done_items = 0;
        while (done_items < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                send_tick();
                done_items++;
            end else if (pick < 86) begin
                send_beat(CMD_WRITE, REG_ADDRESS, addr_byte(), rand_byte(), rand_byte());
                send_beat(CMD_WRITE, REG_ADDRESS, addr_byte(), rand_byte(), rand_byte());
                burst = $urandom_range(1, 4);
                repeat (burst) begin
                    cmd = ($urandom_range(0, 1) == 1) ? CMD_WRITE : CMD_READ;
                    send_beat(cmd, REG_DATA, rand_byte(), rand_byte(), rand_byte());
                end
                done_items += 2 + burst;
            end else if (pick < 88) begin
                send_beat(CMD_SPARE, 3'($urandom_range(0, 7)), rand_byte(), rand_byte(),
                          rand_byte());
            end else begin
                idx = 3'($urandom_range(0, 7));
                cmd = ($urandom_range(0, 1) == 1) ? CMD_WRITE : CMD_READ;
                send_beat(cmd, idx, rand_byte(), rand_byte(), rand_byte());
                if (cmd == CMD_WRITE ? !(idx inside {REG_MASK, REG_STATUS, REG_SCROLL})
                                     : (idx inside {REG_STATUS, REG_OAM_DATA, REG_DATA})) begin
                    done_items++;
                end
            end
        end
    endtask

    initial begin : receiver
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever begin
            gap = ((beats_taken % 128) >= 80) ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            beats_taken++;
            if (beats_taken == 200) begin
                // Long hold-off so that the input side backs up and stalls.
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_ppu_register_port_and_scanline_timer_top: errors");
        $finish;
    end

    initial begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_beat(CMD_TICK, REG_CONTROL, 8'h00, 8'h00, 8'h00);
        send_beat(CMD_TICK, REG_CONTROL, 8'hFF, 8'hFF, 8'hFF);
        send_beat(CMD_WRITE, REG_CONTROL, 8'h84, 8'h00, 8'h00);
        send_beat(CMD_WRITE, REG_MASK, 8'hFF, 8'h00, 8'h00);
        send_beat(CMD_WRITE, REG_STATUS, 8'hFF, 8'h00, 8'h00);
        send_beat(CMD_WRITE, REG_SCROLL, 8'hFF, 8'h00, 8'h00);
        send_beat(CMD_WRITE, REG_OAM_ADDR, 8'hFF, 8'h00, 8'h00);
        send_beat(CMD_WRITE, REG_OAM_DATA, 8'h5A, 8'h00, 8'h00);
        send_beat(CMD_READ, REG_OAM_DATA, 8'h00, 8'h00, 8'h00);
        send_beat(CMD_READ, REG_CONTROL, 8'h00, 8'h00, 8'h00);
        send_beat(CMD_READ, REG_OAM_ADDR, 8'h00, 8'h00, 8'h00);
        send_beat(CMD_WRITE, REG_ADDRESS, 8'h3F, 8'h00, 8'h00);
        send_beat(CMD_WRITE, REG_ADDRESS, 8'hFF, 8'h00, 8'h00);
        send_beat(CMD_WRITE, REG_DATA, 8'hC3, 8'h00, 8'h00);
        send_beat(CMD_WRITE, REG_ADDRESS, 8'hFF, 8'h00, 8'h00);
        send_beat(CMD_WRITE, REG_ADDRESS, 8'hFF, 8'h00, 8'h00);
        send_beat(CMD_WRITE, REG_DATA, 8'h00, 8'h00, 8'h00);
        send_beat(CMD_READ, REG_DATA, 8'h00, 8'h00, 8'hA5);
        send_beat(CMD_READ, REG_DATA, 8'h00, 8'h00, 8'h00);
        send_beat(CMD_WRITE, REG_ADDRESS, 8'h20, 8'h00, 8'h00);
        send_beat(CMD_READ, REG_STATUS, 8'h00, 8'h00, 8'h00);
        send_beat(CMD_WRITE, REG_ADDRESS, 8'h2F, 8'h00, 8'h00);
        send_beat(CMD_WRITE, REG_ADDRESS, 8'hFF, 8'h00, 8'h00);
        send_beat(CMD_READ, REG_DATA, 8'h00, 8'h00, 8'h77);
        send_beat(CMD_SPARE, REG_DATA, 8'hFF, 8'hFF, 8'hFF);

        set_mirroring(1'b1);
        run_random(PHASE_ITEMS);
        set_mirroring(1'b0);
        run_random(PHASE_ITEMS);
        set_mirroring(1'b1);
        run_random(PHASE_ITEMS);

        drain();
        repeat (8) @(posedge clk);
        $display("Sent %0d items through directed checks and three random phases,",
                 items_sent);
        $display("both mirroring modes; %0d frame wraps, %0d NMIs, %0d nametable writes.",
                 frames, nmis, nt_writes);
        if (error_count == 0) begin
            $display("tb_ppu_register_port_and_scanline_timer_top: clean");
        end else begin
            $display("tb_ppu_register_port_and_scanline_timer_top: errors");
        end
        $finish;
    end

endmodule
